>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the allocator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled while reset is low.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a property that must hold in every cycle.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLKD(lbl, clk, rst_n, (expr), msg)

`endif

>>> hdl/fpba_pkg.sv
// Package of the fit-policy block allocator: sizes, codes and FSM state type.
// No dependencies; used by scoped names from the core and its checker.
`timescale 1ns / 1ps

package fpba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);

	// Field widths of the ports.
	localparam int OP_W      = 2;
	localparam int BIDX_W    = 4;
	localparam int SIZE_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 5;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REQ     = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_SCAN,
		ST_WRITE,
		ST_PUSH
	} state_t;

endpackage

>>> hdl/fit_policy_block_allocator_core.sv
// Fit-policy block allocator: capacity and free-space memories with a scan sequencer.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

// Usage.
// Requests enter on the in_ channel (op, block_index, size_value) and one result per
// request leaves on the out_ channel (granted, chosen_block, space_left); both use
// valid/ready. Registers are written on the cfg_ channel, which is always ready.
// A load request writes one capacity; its result goes through ST_PUSH.
// An allocation request reads the free-space memory one block per cycle through
// its single read port, then writes the chosen block back: with L = min(block_count,
// 16) the first L blocks are read, and the next request can be taken in the cycle
// in which the result appears. With block_count at zero no block is read.
// A restart request copies all 16 capacities, one entry per cycle.
// One request is worked on at a time; in_ready is high only while idle.
// A finished result waits in the output register while the receiver stalls, and a
// new request can still be taken; the one after that holds until the output frees.
// Reset clears the per-entry valid bits, so both tables read as zero at once; no
// clearing pass is needed. fit_mode resets to first fit, block_count to 16.
module fit_policy_block_allocator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fpba_pkg::OP_W-1:0]         op,
	input  logic [fpba_pkg::BIDX_W-1:0]       block_index,
	input  logic [fpba_pkg::SIZE_W-1:0]       size_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              granted,
	output logic [fpba_pkg::BIDX_W-1:0]       chosen_block,
	output logic [fpba_pkg::SIZE_W-1:0]       space_left,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpba_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int MAXB = fpba_pkg::MAX_BLOCKS;
	localparam int IW   = fpba_pkg::IDX_BITS;
	localparam int CW   = fpba_pkg::CNT_BITS;
	localparam int SW   = fpba_pkg::SIZE_BITS;

	fpba_pkg::state_t state_q, state_d;

	logic [1:0]      fit_mode_q;
	logic [4:0]      block_count_q;

	logic [SW-1:0]   cap_mem [MAXB];
	logic [SW-1:0]   rem_mem [MAXB];
	logic [MAXB-1:0] cap_vld_q;
	logic [MAXB-1:0] rem_vld_q;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   limit_q;
	logic [IW-1:0]   rd_addr;
	logic            rd_issue;
	logic            rd_v_s1;
	logic [IW-1:0]   rd_idx_s1;
	logic [SW-1:0]   cap_rd_s1;
	logic [SW-1:0]   rem_rd_s1;
	logic            cap_vld_s1;
	logic            rem_vld_s1;

	logic [SW-1:0]   need_q;
	logic            found_q;
	logic [IW-1:0]   best_idx_q;
	logic [SW-1:0]   best_val_q;
	logic [SW-1:0]   room;
	logic            take;

	logic            cap_we;
	logic            rem_we;
	logic [IW-1:0]   rem_wa;
	logic [SW-1:0]   rem_wd;

	logic                        res_granted_q;
	logic [fpba_pkg::BIDX_W-1:0] res_block_q;
	logic [fpba_pkg::SIZE_W-1:0] res_space_q;
	logic                        out_load;
	logic                        out_valid_q;
	logic                        accept;

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign rd_addr   = cnt_q[IW-1:0];
	assign out_valid = out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= fpba_pkg::FIT_FIRST;
			block_count_q <= fpba_pkg::BLOCK_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpba_pkg::REG_FIT_MODE:    fit_mode_q    <= cfg_data[1:0];
				fpba_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_issue = 1'b0;
		cap_we   = 1'b0;
		rem_we   = 1'b0;
		rem_wa   = rd_idx_s1;
		rem_wd   = cap_vld_s1 ? cap_rd_s1 : '0;
		out_load = 1'b0;
		case (state_q)
			fpba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						fpba_pkg::OP_LOAD: begin
							cap_we  = (32'(block_index) < 32'(MAXB));
							state_d = fpba_pkg::ST_PUSH;
						end
						fpba_pkg::OP_REQ:     state_d = fpba_pkg::ST_SCAN;
						fpba_pkg::OP_RESTART: state_d = fpba_pkg::ST_COPY;
						default:              state_d = fpba_pkg::ST_PUSH;
					endcase
				end
			end
			fpba_pkg::ST_COPY: begin
				// Read of entry k overlaps the write-back of entry k-1.
				rd_issue = (cnt_q < CW'(MAXB));
				rem_we   = rd_v_s1;
				if (cnt_q == CW'(MAXB) && !rd_v_s1) begin
					state_d = fpba_pkg::ST_PUSH;
				end
			end
			fpba_pkg::ST_SCAN: begin
				rd_issue = (cnt_q < limit_q);
				if (cnt_q == limit_q && !rd_v_s1) begin
					state_d = fpba_pkg::ST_WRITE;
				end
			end
			fpba_pkg::ST_WRITE: begin
				rem_we  = found_q;
				rem_wa  = best_idx_q;
				rem_wd  = best_val_q - need_q;
				state_d = fpba_pkg::ST_PUSH;
			end
			fpba_pkg::ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = fpba_pkg::ST_IDLE;
				end
			end
			default: state_d = fpba_pkg::ST_IDLE;
		endcase
	end

	// Memories: one write port each, a shared read address, registered read data.
	always_ff @(posedge clk) begin
		if (cap_we) begin
			cap_mem[IW'(block_index)] <= SW'(size_value);
		end
		if (rem_we) begin
			rem_mem[rem_wa] <= rem_wd;
		end
		if (rd_issue) begin
			cap_rd_s1 <= cap_mem[rd_addr];
			rem_rd_s1 <= rem_mem[rd_addr];
		end
	end

	// An entry that was never written reads as zero through its valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_q  <= '0;
			rem_vld_q  <= '0;
			cap_vld_s1 <= 1'b0;
			rem_vld_s1 <= 1'b0;
		end else begin
			if (cap_we) begin
				cap_vld_q[IW'(block_index)] <= 1'b1;
			end
			if (rem_we) begin
				rem_vld_q[rem_wa] <= 1'b1;
			end
			if (rd_issue) begin
				cap_vld_s1 <= cap_vld_q[rd_addr];
				rem_vld_s1 <= rem_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_s1 <= rd_addr;
		end
		if (accept) begin
			need_q <= SW'(size_value);
			if (32'(block_count_q) > 32'(MAXB)) begin
				limit_q <= CW'(MAXB);
			end else begin
				limit_q <= CW'(block_count_q);
			end
		end
	end

	// Scan compare on the registered read data.
	assign room = rem_vld_s1 ? rem_rd_s1 : '0;

	always_comb begin
		take = 1'b0;
		if (room >= need_q) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_mode_q == fpba_pkg::FIT_BEST) begin
				take = (room < best_val_q);
			end else if (fit_mode_q == fpba_pkg::FIT_WORST) begin
				take = (room > best_val_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (accept) begin
			found_q <= 1'b0;
		end else if (state_q == fpba_pkg::ST_SCAN && rd_v_s1 && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fpba_pkg::ST_SCAN && rd_v_s1 && take) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= room;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_granted_q <= 1'b0;
			res_block_q   <= '0;
			res_space_q   <= '0;
		end else if (state_q == fpba_pkg::ST_WRITE && found_q) begin
			res_granted_q <= 1'b1;
			res_block_q   <= fpba_pkg::BIDX_W'(best_idx_q);
			res_space_q   <= fpba_pkg::SIZE_W'(rem_wd);
		end
	end

	// Output register: holds the result while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			granted      <= res_granted_q;
			chosen_block <= res_block_q;
			space_left   <= res_space_q;
		end
	end

endmodule

>>> hdl/fpba_checker.sv
// Port-level checker of the fit-policy block allocator, bound to the core.
// Depends on fpba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpba_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              granted,
	input logic [fpba_pkg::BIDX_W-1:0]       chosen_block,
	input logic [fpba_pkg::SIZE_W-1:0]       space_left,
	input logic                              cfg_ready
);

	// A stalled result keeps its valid and its payload.
	`ASSERT_CLKD(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(chosen_block) && $stable(space_left), "stalled result changed")

	// Only one request is worked on at a time.
	`ASSERT_CLKD(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready, "request taken while busy")

	// A result without a grant carries zero block and zero space.
	`ASSERT_CLKD(a_no_grant_zero, clk, arst_n, out_valid && !granted |-> chosen_block == '0 && space_left == '0, "refused result not zeroed")

	// The configuration port never stalls.
	`ASSERT_ALWAYS(a_cfg_ready, clk, arst_n, cfg_ready, "configuration port stalled")

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.granted      (granted),
	.chosen_block (chosen_block),
	.space_left   (space_left),
	.cfg_ready    (cfg_ready)
);

>>> tb/fit_policy_block_allocator_core_test.sv
// Self-checking testbench of fit_policy_block_allocator_core: directed rows, then random phases.
// Depends on fpba_pkg and the core; predicts all but typed rows with its own copy of both tables.
`timescale 1ns / 1ps

module fit_policy_block_allocator_core_test;

	import fpba_pkg::*;

	// Codes the package leaves unnamed: the op value that the block ignores,
	// and a fit-mode write whose upper bits must be dropped (mode 3, first fit).
	localparam logic [OP_W-1:0]      OP_IGNORED   = 2'd3;
	localparam logic [CFG_DAT_W-1:0] FIT_ODD_DATA = 5'b11111;

	typedef struct packed {
		logic              granted;
		logic [BIDX_W-1:0] chosen_block;
		logic [SIZE_W-1:0] space_left;
	} alloc_result_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [OP_W-1:0]      op;
		logic [BIDX_W-1:0]    blk;
		logic [SIZE_W-1:0]    size;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [CFG_DAT_W-1:0] reg_data;
		logic                 typed;
		alloc_result_t        want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [OP_W-1:0]      op;
	logic [BIDX_W-1:0]    block_index;
	logic [SIZE_W-1:0]    size_value;
	logic                 out_valid;
	logic                 out_ready;
	logic                 granted;
	logic [BIDX_W-1:0]    chosen_block;
	logic [SIZE_W-1:0]    space_left;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Predictor state: capacities, free space and the two registers.
	logic [SIZE_W-1:0] cap_tbl  [0:MAX_BLOCKS-1];
	logic [SIZE_W-1:0] free_tbl [0:MAX_BLOCKS-1];
	logic [1:0]        model_mode;
	logic [4:0]        model_count;

	alloc_result_t pending_outcomes [$];
	stim_row_t     directed_rows [$];

	int  fault_count;
	int  n_requests, n_placed, n_loads, n_restarts, n_ignored, n_reg_writes;
	int  stall_left;
	bit  quiet_tail;

	fit_policy_block_allocator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.block_index  (block_index),
		.size_value   (size_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.chosen_block (chosen_block),
		.space_left   (space_left),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Works out the result of one accepted request and updates the tables.
	function automatic alloc_result_t place_request(logic [OP_W-1:0] o, logic [BIDX_W-1:0] b,
			logic [SIZE_W-1:0] sz);
		alloc_result_t res;
		int pick;
		int limit;
		res = '0;
		pick = -1;
		case (o)
			OP_LOAD: begin
				cap_tbl[b] = sz;
				n_loads++;
			end
			OP_RESTART: begin
				free_tbl = cap_tbl;
				n_restarts++;
			end
			OP_REQ: begin
				limit = (model_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(model_count);
				// First fit keeps the first hit because only best and worst fit replace it.
				for (int k = 0; k < limit; k++) begin
					if (free_tbl[k] >= sz) begin
						if (pick < 0)
							pick = k;
						else if (model_mode == FIT_BEST && free_tbl[k] < free_tbl[pick])
							pick = k;
						else if (model_mode == FIT_WORST && free_tbl[k] > free_tbl[pick])
							pick = k;
					end
				end
				if (pick >= 0) begin
					free_tbl[pick] = free_tbl[pick] - sz;
					res.granted = 1'b1;
					res.chosen_block = pick[BIDX_W-1:0];
					res.space_left = free_tbl[pick];
					n_placed++;
				end
				n_requests++;
			end
			default: n_ignored++;
		endcase
		return res;
	endfunction

	function automatic stim_row_t item_row(logic [OP_W-1:0] o, logic [BIDX_W-1:0] b,
			logic [SIZE_W-1:0] sz);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.op = o;
		r.blk = b;
		r.size = sz;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [OP_W-1:0] o, logic [BIDX_W-1:0] b,
			logic [SIZE_W-1:0] sz, logic g, logic [BIDX_W-1:0] cb, logic [SIZE_W-1:0] sl);
		stim_row_t r;
		r = item_row(o, b, sz);
		r.typed = 1'b1;
		r.want = '{g, cb, sl};
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] d);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_sel = sel;
		r.reg_data = d;
		return r;
	endfunction

	// Drops in_valid and waits until every expected result has been taken.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DAT_W-1:0] d);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		if (sel == REG_FIT_MODE)
			model_mode = d[1:0];
		else
			model_count = d;
		n_reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input logic [OP_W-1:0] o, input logic [BIDX_W-1:0] b,
			input logic [SIZE_W-1:0] sz, input logic typed, input alloc_result_t want);
		alloc_result_t res;
		int gap;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		block_index <= b;
		size_value <= sz;
		do @(posedge clk); while (!in_ready);
		res = place_request(o, b, sz);
		pending_outcomes.push_back(typed ? want : res);
	endtask

	// Result checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t exp_res;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding: granted %0d block %0d space %0d",
					granted, chosen_block, space_left);
				fault_count++;
			end else begin
				exp_res = pending_outcomes.pop_front();
				if (granted !== exp_res.granted) begin
					$error("granted: expected %0d, got %0d", exp_res.granted, granted);
					fault_count++;
				end
				if (chosen_block !== exp_res.chosen_block) begin
					$error("chosen_block: expected %0d, got %0d", exp_res.chosen_block,
						chosen_block);
					fault_count++;
				end
				if (space_left !== exp_res.space_left) begin
					$error("space_left: expected %0d, got %0d", exp_res.space_left, space_left);
					fault_count++;
				end
			end
		end
	end

	// Receiver: stalls in random bursts between ready stretches.
	always @(negedge clk) begin
		if (!arst_n || quiet_tail) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 16);
		end else begin
			out_ready <= 1'b1;
			stall_left = $urandom_range(0, 40);
		end
	end

	initial begin
		#4_000_000;
		$display("fit_policy_block_allocator_core_test NOT OK");
		$finish;
	end

	initial begin
		alloc_result_t none;
		logic [OP_W-1:0]   o;
		logic [SIZE_W-1:0] sz;
		int fills;
		int roll;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LOAD;
		block_index = '0;
		size_value = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FIT_MODE;
		cfg_data = '0;
		stall_left = 0;
		quiet_tail = 1'b0;
		fault_count = 0;
		none = '0;
		foreach (cap_tbl[k]) begin
			cap_tbl[k] = '0;
			free_tbl[k] = '0;
		end
		model_mode = FIT_FIRST;
		model_count = BLOCK_COUNT_RESET;

		directed_rows = '{
			// Empty tables: a zero-size request still fits block 0, anything larger does not.
			typed_row(OP_REQ, 4'd0, 16'd0, 1'b1, 4'd0, 16'd0),
			typed_row(OP_REQ, 4'd0, 16'd1, 1'b0, 4'd0, 16'd0),
			typed_row(OP_LOAD, 4'd0, 16'hFFFF, 1'b0, 4'd0, 16'd0),
			typed_row(OP_LOAD, 4'd15, 16'd100, 1'b0, 4'd0, 16'd0),
			item_row(OP_LOAD, 4'd5, 16'd300),
			item_row(OP_LOAD, 4'd9, 16'd300),
			typed_row(OP_RESTART, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
			typed_row(OP_REQ, 4'd0, 16'hFFFF, 1'b1, 4'd0, 16'd0),
			typed_row(OP_IGNORED, 4'd3, 16'hFFFF, 1'b0, 4'd0, 16'd0),
			item_row(OP_REQ, 4'd0, 16'd50),
			reg_row(REG_FIT_MODE, {3'b000, FIT_BEST}),
			item_row(OP_REQ, 4'd0, 16'd50),
			item_row(OP_REQ, 4'd0, 16'd50),
			reg_row(REG_FIT_MODE, {3'b000, FIT_WORST}),
			item_row(OP_REQ, 4'd0, 16'd10),
			item_row(OP_REQ, 4'd0, 16'd260),
			reg_row(REG_FIT_MODE, FIT_ODD_DATA),
			item_row(OP_REQ, 4'd0, 16'd1),
			reg_row(REG_BLOCK_COUNT, 5'd0),
			typed_row(OP_REQ, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
			reg_row(REG_BLOCK_COUNT, 5'd31),
			item_row(OP_REQ, 4'd0, 16'd30),
			reg_row(REG_BLOCK_COUNT, 5'd6),
			item_row(OP_REQ, 4'd0, 16'd220),
			reg_row(REG_FIT_MODE, {3'b000, FIT_BEST}),
			reg_row(REG_BLOCK_COUNT, BLOCK_COUNT_RESET),
			// Two equal blocks: best fit must take the lower index.
			item_row(OP_LOAD, 4'd2, 16'hAAAA),
			item_row(OP_LOAD, 4'd3, 16'hAAAA),
			item_row(OP_RESTART, 4'd0, 16'd0),
			item_row(OP_REQ, 4'd0, 16'h5555)
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG)
				write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_data);
			else
				send_item(directed_rows[i].op, directed_rows[i].blk, directed_rows[i].size,
					directed_rows[i].typed, directed_rows[i].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			quiet_tail = (phase == 7);
			write_reg(REG_FIT_MODE, (phase < 4) ? CFG_DAT_W'(phase) : 5'($urandom_range(0, 31)));
			case (phase % 4)
				0: write_reg(REG_BLOCK_COUNT, BLOCK_COUNT_RESET);
				1: write_reg(REG_BLOCK_COUNT, 5'($urandom_range(1, 16)));
				2: write_reg(REG_BLOCK_COUNT, 5'($urandom_range(17, 31)));
				default: write_reg(REG_BLOCK_COUNT, 5'($urandom_range(0, 31)));
			endcase

			// Fill part of the table and restart, so that requests find room.
			fills = $urandom_range(2, 16);
			repeat (fills) begin
				sz = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0)
					: 16'($urandom);
				send_item(OP_LOAD, 4'($urandom_range(0, 15)), sz, 1'b0, none);
			end
			send_item(OP_RESTART, 4'($urandom_range(0, 15)), 16'($urandom), 1'b0, none);

			for (int n = 0; n < 100; n++) begin
				if (phase == 3 && n == 50)
					settle();
				roll = $urandom_range(0, 99);
				if (roll < 70)
					o = OP_REQ;
				else if (roll < 85)
					o = OP_LOAD;
				else if (roll < 93)
					o = OP_RESTART;
				else
					o = OP_IGNORED;
				roll = $urandom_range(0, 9);
				if (o == OP_REQ)
					sz = (roll < 5) ? 16'($urandom_range(0, 2000)) : (roll < 8) ? 16'($urandom)
						: (roll == 8) ? 16'd0 : 16'hFFFF;
				else
					sz = (roll == 0) ? 16'hFFFF : (roll == 1) ? 16'd0 : 16'($urandom);
				send_item(o, 4'($urandom_range(0, 15)), sz, 1'b0, none);
			end
		end

		settle();
		repeat (30) @(posedge clk);
		$display("Ran %0d requests (%0d placed), %0d loads, %0d restarts, %0d ignored ops,",
			n_requests, n_placed, n_loads, n_restarts, n_ignored);
		$display("and %0d register writes over all four fit modes and block counts 0 to 31.",
			n_reg_writes);
		if (fault_count == 0)
			$display("fit_policy_block_allocator_core_test OK");
		else
			$display("fit_policy_block_allocator_core_test NOT OK");
		$finish;
	end

endmodule
